// ----- rtl/core/lkv_pkg.sv -----
package lkv_pkg;

  // Geometry of the cache.
  localparam int CAPACITY = 16;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int RANK_W   = IDX_W;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 5;
  localparam int CAP_RST  = 16;

  // Request opcodes.
  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Result status codes.
  localparam logic [2:0] STS_HIT         = 3'd0;
  localparam logic [2:0] STS_MISS        = 3'd1;
  localparam logic [2:0] STS_UPDATED     = 3'd2;
  localparam logic [2:0] STS_INSERTED    = 3'd3;
  localparam logic [2:0] STS_INS_EVICT   = 3'd4;
  localparam logic [2:0] STS_DELETED     = 3'd5;
  localparam logic [2:0] STS_DELETE_MISS = 3'd6;
  localparam logic [2:0] STS_REJECTED    = 3'd7;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] new_value;
    logic             new_is_directory;
    logic             value_present;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] out_value;
    logic             out_is_directory;
    logic [KEY_W-1:0] evicted_key;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

// ----- rtl/core/lru_key_value_cache.sv -----
// LRU key-value cache.
//
// Requests arrive on req/req_valid/req_stall and results leave on
// res/res_valid/res_stall. A request is taken at a rising edge where its
// valid is high and its stall is low; every request yields exactly one
// result. The capacity register is written through cfg_we/cfg_data; the
// user must do so only while the block is idle, which it does not enforce.
// Zero acts as one and values above the table depth act as the full depth.
//
// Each request walks all 16 entries through one shared key comparator, one
// entry per cycle, then commits the table and recency updates. A new request
// is taken only once that commit is done and the block is back in idle.
// req_stall is high for the whole walk and commit.
//
// The result sits in an output register. While res_stall holds it, the block
// still accepts and walks the next request; the commit of that request
// waits until the output register is free. A synchronous reset empties the
// table, drops any pending result and restores the capacity to 16.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state, state_next;

  // Request held during the walk.
  req_t req_q;

  // Walk position and what the walk has found so far.
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_last;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [VAL_W-1:0]  hit_value;
  logic              hit_dir;
  logic              lru_found;
  logic [IDX_W-1:0]  lru_idx;
  logic [KEY_W-1:0]  lru_key;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // Entry table. Only valid entries are ever read, so only the valid bits
  // and the occupancy count are reset.
  logic [CAPACITY-1:0] entry_valid;
  logic [KEY_W-1:0]    entry_key   [CAPACITY];
  logic [VAL_W-1:0]    entry_value [CAPACITY];
  logic                entry_dir   [CAPACITY];
  logic [RANK_W-1:0]   entry_rank  [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [CFG_W-1:0]    cap_q;

  // Sequencer strobes.
  logic accept;
  logic scan_en;
  logic commit;
  logic res_take;

  // Commit decisions.
  logic                   is_fetch, is_update, is_delete;
  logic                   upd_ok;
  logic [CFG_W+CNT_W-1:0] cap_wide;
  logic [CNT_W-1:0]       cap_eff;
  logic                   act_touch;
  logic                   act_write;
  logic                   act_drop;
  logic                   act_insert;
  logic                   evict;
  logic [IDX_W-1:0]       slot;
  logic                   entry_match;
  logic                   entry_is_lru;
  res_t                   res_next;

  assign accept    = req_valid && !req_stall;
  assign res_take  = res_valid && !res_stall;
  assign scan_last = (scan_idx == IDX_W'(CAPACITY - 1));

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall = 1'b1;
    scan_en   = 1'b0;
    commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_SCAN: begin
        scan_en = 1'b1;
      end
      ST_COMMIT: begin
        commit = !res_valid || !res_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The entry under the comparator this cycle.
  assign entry_match  = entry_valid[scan_idx] && (entry_key[scan_idx] == req_q.key);
  // The least recent entry always holds the rank one below the count.
  assign entry_is_lru = entry_valid[scan_idx] &&
                        ({1'b0, entry_rank[scan_idx]} == CNT_W'(count - 1'b1));

  // Walk registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req;
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      lru_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (scan_en) begin
      if (!scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (entry_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
        hit_rank  <= entry_rank[scan_idx];
        hit_value <= entry_value[scan_idx];
        hit_dir   <= entry_dir[scan_idx];
      end
      if (entry_is_lru) begin
        lru_found <= 1'b1;
        lru_idx   <= scan_idx;
        lru_key   <= entry_key[scan_idx];
      end
      if (!entry_valid[scan_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
    end
  end

  // Effective capacity: zero acts as one, large values clamp to the depth.
  always_comb begin
    cap_wide = {{CNT_W{1'b0}}, cap_q};
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > (CFG_W + CNT_W)'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = cap_wide[CNT_W-1:0];
    end
  end

  // What the commit cycle does, and the result it produces.
  always_comb begin
    is_fetch  = (req_q.opcode == OP_FETCH);
    is_update = (req_q.opcode == OP_UPDATE);
    is_delete = (req_q.opcode == OP_DELETE);
    upd_ok    = is_update && req_q.value_present;

    act_touch  = hit_found && (is_fetch || upd_ok);
    act_write  = hit_found && upd_ok;
    act_drop   = hit_found && is_delete;
    evict      = upd_ok && !hit_found && (count >= cap_eff) && lru_found;

    // A freed least-recent entry may be the lowest free slot.
    if (evict && !(free_found && (free_idx < lru_idx))) begin
      slot = lru_idx;
    end else begin
      slot = free_idx;
    end
    act_insert = upd_ok && !hit_found && (evict || free_found);

    res_next = '0;
    if (is_fetch) begin
      if (hit_found) begin
        res_next.status           = STS_HIT;
        res_next.out_value        = hit_value;
        res_next.out_is_directory = hit_dir;
      end else begin
        res_next.status = STS_MISS;
      end
    end else if (upd_ok) begin
      if (hit_found) begin
        res_next.status = STS_UPDATED;
      end else if (evict) begin
        res_next.status      = STS_INS_EVICT;
        res_next.evicted_key = lru_key;
      end else begin
        res_next.status = STS_INSERTED;
      end
    end else if (is_delete) begin
      res_next.status = hit_found ? STS_DELETED : STS_DELETE_MISS;
    end else begin
      res_next.status = STS_REJECTED;
    end
  end

  // Control state: valid bits, occupancy, capacity, result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      count       <= '0;
      cap_q       <= CFG_W'(CAP_RST);
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_q <= cfg_data;
      end
      if (commit) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      if (commit && act_drop) begin
        entry_valid[hit_idx] <= 1'b0;
        count                <= count - 1'b1;
      end
      if (commit && act_insert) begin
        if (evict) begin
          entry_valid[lru_idx] <= 1'b0;
        end else begin
          count <= count + 1'b1;
        end
        entry_valid[slot] <= 1'b1;
      end
    end
  end

  // Payload state: entry contents, recency ranks and the result register.
  always_ff @(posedge clk) begin
    if (commit) begin
      res <= res_next;
      if (act_touch) begin
        // Entries more recent than the hit age by one.
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_valid[i] && (entry_rank[i] < hit_rank)) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
        entry_rank[hit_idx] <= '0;
      end
      if (act_write) begin
        entry_value[hit_idx] <= req_q.new_value;
        entry_dir[hit_idx]   <= req_q.new_is_directory;
      end
      if (act_drop) begin
        // Entries less recent than the freed one move up by one.
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_valid[i] && (entry_rank[i] > hit_rank)) begin
            entry_rank[i] <= entry_rank[i] - 1'b1;
          end
        end
      end
      if (act_insert) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_valid[i] && !(evict && (IDX_W'(i) == lru_idx))) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
        entry_key[slot]   <= req_q.key;
        entry_value[slot] <= req_q.new_value;
        entry_dir[slot]   <= req_q.new_is_directory;
        entry_rank[slot]  <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/lkv_checker.sv -----
module lkv_checker
  import lkv_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // Reset drops any pending result.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result still valid after reset");

  // The block is busy the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while the previous one is still walking");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without a request in progress");

  // A held result does not change.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  // Value and flag are only carried on a hit, the evicted key only on eviction.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.status == STS_HIT) ||
                   (res.out_value == '0 && !res.out_is_directory)) &&
                  ((res.status == STS_INS_EVICT) || (res.evicted_key == '0)))
    else $error("result carries payload that its status does not allow");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ----- sim/tb_lru_key_value_cache.sv -----
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  // The opcode space has one code that the block does not define. It must be
  // answered as rejected and must leave the table alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A small pool of keys keeps the hit rate high enough to reach updates,
  // recency reordering and evictions. A few random keys are mixed in as misses.
  localparam int POOL_SIZE = 24;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 8;
  // Settling time after a drain. It covers one request's walk and commit with margin.
  localparam int SETTLE_CYCLES = 24;
  // The longest quiet stretch in a correct run is a result stall plus a send
  // gap plus one lookup. This is many times that.
  localparam int QUIET_LIMIT = 3000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_t             res;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Requests waiting to be sent, and the results that the accepted requests
  // must produce, oldest first.
  req_t pending_reqs[$];
  res_t expected_results[$];

  // Shadow copy of the cache: one line per table entry, with its age in the
  // recency order (0 is the most recently used line).
  bit               line_valid [CAPACITY];
  logic [KEY_W-1:0] line_key   [CAPACITY];
  logic [VAL_W-1:0] line_value [CAPACITY];
  bit               line_dir   [CAPACITY];
  int unsigned      line_age   [CAPACITY];
  int unsigned      line_count;
  logic [CFG_W-1:0] cap_setting;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      pool_span = POOL_SIZE;
  logic [CFG_W-1:0] cap_steps [NUM_PHASES];

  bit          failed = 1'b0;
  bit          req_took = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_clock = 0;
  bit          stall_level = 1'b0;

  lru_key_value_cache u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow cache
  // ---------------------------------------------------------------------------

  // Exact key match over all valid lines; -1 when the key is absent.
  function automatic int find_line(logic [KEY_W-1:0] k);
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Move a line to the front of the recency order. Only the lines that were
  // more recent than it grow older, so the ages stay a dense 0..count-1.
  function automatic void make_most_recent(int idx);
    int unsigned was;
    was = line_age[idx];
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_age[i] < was) line_age[i]++;
    end
    line_age[idx] = 0;
  endfunction

  // Free a line and close the hole it leaves in the recency order.
  function automatic void free_line(int idx);
    int unsigned was;
    was = line_age[idx];
    line_valid[idx] = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_age[i] > was) line_age[i]--;
    end
    if (line_count > 0) line_count--;
  endfunction

  // Apply one accepted request to the shadow cache and return the result the
  // block must produce for it.
  function automatic res_t cache_outcome(req_t r);
    res_t        o;
    int          hit;
    int          victim;
    int          slot;
    int unsigned room;
    o = '0;
    o.status = STS_REJECTED;
    // A zero capacity acts as one; anything above the table depth acts as
    // the full depth.
    if (cap_setting == 0) room = 1;
    else if (cap_setting > CAPACITY) room = CAPACITY;
    else room = 32'(cap_setting);
    hit = find_line(r.key);
    case (r.opcode)
      OP_FETCH: begin
        if (hit >= 0) begin
          make_most_recent(hit);
          o.status = STS_HIT;
          o.out_value = line_value[hit];
          o.out_is_directory = line_dir[hit];
        end else begin
          o.status = STS_MISS;
        end
      end
      OP_UPDATE: begin
        // An update with no value is rejected even when the key is present.
        if (!r.value_present) begin
          o.status = STS_REJECTED;
        end else if (hit >= 0) begin
          line_value[hit] = r.new_value;
          line_dir[hit] = r.new_is_directory;
          make_most_recent(hit);
          o.status = STS_UPDATED;
        end else begin
          o.status = STS_INSERTED;
          // When the cache is at (or, after a capacity cut, above) its limit,
          // exactly one least recent line goes before the insert.
          if (line_count >= room) begin
            victim = -1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) begin
                victim = i;
              end
            end
            if (victim >= 0) begin
              o.evicted_key = line_key[victim];
              free_line(victim);
              o.status = STS_INS_EVICT;
            end
          end
          // The new entry takes the lowest-numbered free line.
          slot = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (!line_valid[i] && slot < 0) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (line_valid[i]) line_age[i]++;
            end
            line_valid[slot] = 1'b1;
            line_key[slot] = r.key;
            line_value[slot] = r.new_value;
            line_dir[slot] = r.new_is_directory;
            line_age[slot] = 0;
            line_count++;
          end
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          free_line(hit);
          o.status = STS_DELETED;
        end else begin
          o.status = STS_DELETE_MISS;
        end
      end
      default: begin
        o.status = STS_REJECTED;
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic [1:0] op, logic [KEY_W-1:0] k,
                                    logic [VAL_W-1:0] v, bit dir, bit present);
    req_t r;
    r.opcode = op;
    r.key = k;
    r.new_value = v;
    r.new_is_directory = dir;
    r.value_present = present;
    return r;
  endfunction

  // Mostly fetches and updates on keys from the active part of the pool, so
  // that hits, rewrites and evictions all happen often. About one key in ten
  // is fresh and random, and a few requests carry the unused opcode.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.opcode = OP_FETCH;
    else if (pick < 75) r.opcode = OP_UPDATE;
    else if (pick < 93) r.opcode = OP_DELETE;
    else r.opcode = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) r.key = {$urandom, $urandom};
    else r.key = key_pool[$urandom_range(0, pool_span - 1)];
    case ($urandom_range(0, 15))
      0: begin
        r.new_value = '0;
      end
      1: begin
        r.new_value = '1;
      end
      default: begin
        r.new_value = {$urandom, $urandom};
      end
    endcase
    r.new_is_directory = 1'($urandom_range(0, 1));
    if (r.opcode == OP_UPDATE) r.value_present = ($urandom_range(0, 9) != 0);
    else r.value_present = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. A
  // request that is offered stays put until the block takes it.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: the pattern is redrawn periodically at random among no
  // stalls at all, short flickering stalls and long holds.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    stall_clock++;
    if (stall_clock % 400 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_level = ~stall_level;
      case (stall_mode)
        0: begin
          stall_level = 1'b0;
          stall_left = 8;
        end
        1: begin
          stall_left = $urandom_range(0, 4);
        end
        default: begin
          stall_left = stall_level ? $urandom_range(10, 60) : $urandom_range(0, 20);
        end
      endcase
    end
    res_stall <= stall_level;
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, where the inputs have
  // been steady since the falling edge before it.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    res_t want;
    req_took = 1'b0;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        line_valid[i] = 1'b0;
        line_age[i] = 0;
      end
      line_count = 0;
      cap_setting = CFG_W'(CAP_RST);
      quiet_cycles = 0;
    end else begin
      if (cfg_we) cap_setting = cfg_data;
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", res.status);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            failed = 1'b1;
          end
          if (res.out_value !== want.out_value) begin
            $error("out_value: expected %h, got %h", want.out_value, res.out_value);
            failed = 1'b1;
          end
          if (res.out_is_directory !== want.out_is_directory) begin
            $error("out_is_directory: expected %0b, got %0b",
                   want.out_is_directory, res.out_is_directory);
            failed = 1'b1;
          end
          if (res.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, res.evicted_key);
            failed = 1'b1;
          end
        end
      end
      if (req_valid && !req_stall) begin
        req_took = 1'b1;
        expected_results.push_back(cache_outcome(req));
      end
      if (req_took || (res_valid && !res_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // The run ends here if the handshakes stop moving for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until every queued request has gone in and every result has come
  // out, then let the block finish any internal commit before going on.
  task automatic drain_and_settle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single-cycle write of the capacity register, done only while idle.
  task automatic set_capacity(logic [CFG_W-1:0] cap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned room;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    // Capacities in order: one, zero (acts as one), a middle value, the
    // register maximum (acts as the full table), the full table, then a cut
    // to three with the table still well filled, so each insert evicts
    // exactly one of the surplus entries, then two and eight.
    cap_steps = '{5'd1, 5'd0, 5'd5, 5'd31, 5'd16, 5'd3, 5'd2, 5'd8};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset capacity: misses on an empty table, a
    // rejected update both for an absent and for a present key, extreme keys
    // and values, a rewrite, the unused opcode, and deletes that hit and miss.
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_DELETE, '0, '0, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_UPDATE, '0, '1, 1'b1, 1'b0));
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_UPDATE, '0, '1, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_UPDATE, '1, '0, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_UPDATE, '0, 64'h5555_5555_5555_5555, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_UPDATE, '0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_FETCH,  '1, '0, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_UNUSED, '0, '1, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_FETCH,  '0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_DELETE, '1, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_FETCH,  '1, '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_DELETE, '1, '1, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_UPDATE, key_pool[2], 64'h0123_4567_89AB_CDEF, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_UPDATE, key_pool[3], 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_FETCH,  key_pool[2], '0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_FETCH,  key_pool[3], '0, 1'b0, 1'b0));
    drain_and_settle();

    // Random phases, each under its own capacity. The active key range
    // tracks the capacity so that small caches still see hits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(cap_steps[p]);
      if (cap_steps[p] == 0) room = 1;
      else if (cap_steps[p] > CAPACITY) room = CAPACITY;
      else room = 32'(cap_steps[p]);
      pool_span = (room + 4 < POOL_SIZE) ? room + 4 : POOL_SIZE;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_reqs.push_back(random_req());
      drain_and_settle();
    end

    if (!failed) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule

// ----- lru_key_value_cache.f -----
rtl/core/lkv_pkg.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkv_checker.sv
sim/tb_lru_key_value_cache.sv
